@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

// next-cycle implication that also runs through reset
`define ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle, reset");

`endif

@@ hw/rtl/h4hci_pkg.sv @@
// ----------------------------------------------------------------------------
// h4hci_pkg
// types and constants shared by the h4 deframer modules
// ----------------------------------------------------------------------------
package h4hci_pkg;

    localparam logic [7:0]  TYPE_EVT         = 8'h04;
    localparam logic [7:0]  TYPE_ACL         = 8'h02;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd1024;
    localparam int          PADDR_W          = 3;
    localparam logic        REG_IDX_MAX_LEN  = 1'b0;

    localparam logic        KIND_EVT         = 1'b0;
    localparam logic        KIND_ACL         = 1'b1;

    localparam logic        STATUS_OK        = 1'b0;
    localparam logic        STATUS_TOO_LONG  = 1'b1;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_EVT_HDR = 2'd1,
        PH_ACL_HDR = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // one output beat plus its valid flag
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       packet_kind;
        logic       first_byte;
        logic       last_byte;
        logic       status;
    } beat_t;

endpackage

@@ hw/rtl/h4hci_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// h4hci_cfg_regs
// apb register file holding the payload length limit
// ----------------------------------------------------------------------------
module h4hci_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [h4hci_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [15:0]                   max_len
);

    logic [15:0] max_len_reg;
    logic [15:0] max_len_next;
    logic        wr_hit;

    // word index is paddr[2]
    assign wr_hit = psel && penable && pwrite
                    && (paddr[2] == h4hci_pkg::REG_IDX_MAX_LEN);

    always_comb begin
        max_len_next = max_len_reg;
        if (wr_hit) begin
            max_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= h4hci_pkg::MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == h4hci_pkg::REG_IDX_MAX_LEN) begin
            prdata = {16'd0, max_len_reg};
        end
    end

    assign pready  = 1'b1;
    assign max_len = max_len_reg;

endmodule

@@ hw/rtl/h4hci_fsm.sv @@
// ----------------------------------------------------------------------------
// h4hci_fsm
// packet phase tracking and per-byte result decode
// ----------------------------------------------------------------------------
module h4hci_fsm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    input  logic [15:0]           max_len,
    output h4hci_pkg::beat_t      beat
);

    h4hci_pkg::phase_t phase_reg, phase_next;
    logic        kind_reg,      kind_next;
    logic [1:0]  hdr_cnt_reg,   hdr_cnt_next;
    logic [7:0]  len_low_reg,   len_low_next;
    logic [15:0] remaining_reg, remaining_next;

    logic        hdr_done;
    logic [15:0] hdr_len;
    logic        too_long;
    logic        zero_len;

    // header end: second event byte or fourth acl byte
    always_comb begin
        hdr_done = 1'b0;
        hdr_len  = {8'd0, rx_byte};
        case (phase_reg)
            h4hci_pkg::PH_EVT_HDR: begin
                hdr_done = (hdr_cnt_reg != 2'd0);
                hdr_len  = {8'd0, rx_byte};
            end
            h4hci_pkg::PH_ACL_HDR: begin
                hdr_done = (hdr_cnt_reg == 2'd3);
                hdr_len  = {rx_byte, len_low_reg};
            end
            default: begin
                hdr_done = 1'b0;
            end
        endcase
    end

    assign too_long = (hdr_len > max_len);
    assign zero_len = (hdr_len == 16'd0);

    // next state
    always_comb begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_low_next   = len_low_reg;
        remaining_next = remaining_reg;
        if (accept) begin
            case (phase_reg)
                h4hci_pkg::PH_EVT_HDR,
                h4hci_pkg::PH_ACL_HDR: begin
                    if (hdr_done) begin
                        hdr_cnt_next = 2'd0;
                        if (too_long || zero_len) begin
                            phase_next = h4hci_pkg::PH_TYPE;
                        end else begin
                            phase_next     = h4hci_pkg::PH_PAYLOAD;
                            remaining_next = hdr_len;
                        end
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                        if (hdr_cnt_reg == 2'd2) begin
                            len_low_next = rx_byte;
                        end
                    end
                end
                h4hci_pkg::PH_PAYLOAD: begin
                    if (remaining_reg <= 16'd1) begin
                        remaining_next = 16'd0;
                        phase_next     = h4hci_pkg::PH_TYPE;
                    end else begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                end
                default: begin
                    hdr_cnt_next = 2'd0;
                    if (rx_byte == h4hci_pkg::TYPE_EVT) begin
                        kind_next  = h4hci_pkg::KIND_EVT;
                        phase_next = h4hci_pkg::PH_EVT_HDR;
                    end else if (rx_byte == h4hci_pkg::TYPE_ACL) begin
                        kind_next  = h4hci_pkg::KIND_ACL;
                        phase_next = h4hci_pkg::PH_ACL_HDR;
                    end
                end
            endcase
        end
    end

    // result decode
    always_comb begin
        beat.valid       = 1'b0;
        beat.data_byte   = rx_byte;
        beat.packet_kind = kind_reg;
        beat.first_byte  = 1'b0;
        beat.last_byte   = 1'b0;
        beat.status      = h4hci_pkg::STATUS_OK;
        case (phase_reg)
            h4hci_pkg::PH_EVT_HDR,
            h4hci_pkg::PH_ACL_HDR: begin
                beat.valid      = accept;
                beat.first_byte = (hdr_cnt_reg == 2'd0);
                if (hdr_done) begin
                    beat.last_byte = too_long || zero_len;
                    beat.status    = too_long ? h4hci_pkg::STATUS_TOO_LONG
                                              : h4hci_pkg::STATUS_OK;
                end
            end
            h4hci_pkg::PH_PAYLOAD: begin
                beat.valid     = accept;
                beat.last_byte = (remaining_reg <= 16'd1);
            end
            default: begin
                beat.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= h4hci_pkg::PH_TYPE;
            kind_reg      <= h4hci_pkg::KIND_EVT;
            hdr_cnt_reg   <= 2'd0;
            len_low_reg   <= 8'd0;
            remaining_reg <= 16'd0;
        end else begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            len_low_reg   <= len_low_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

@@ hw/rtl/h4hci_out_stage.sv @@
// ----------------------------------------------------------------------------
// h4hci_out_stage
// result register on the master side
// ----------------------------------------------------------------------------
module h4hci_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  h4hci_pkg::beat_t     beat,
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    logic             valid_reg, valid_next;
    h4hci_pkg::beat_t data_reg,  data_next;

    // free when empty or draining this cycle
    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = beat.valid;
            if (beat.valid) begin
                data_next = beat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.data_byte;
    assign m_tuser  = {data_reg.status, data_reg.first_byte, data_reg.packet_kind};
    assign m_tlast  = data_reg.last_byte;

endmodule

@@ hw/rtl/h4_hci_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// h4_hci_packet_deframer
// h4 uart receive deframer for hci event and acl data packets
// ----------------------------------------------------------------------------
//
//   channel   | direction | payload                                 | handshake
//   ----------+-----------+-----------------------------------------+-----------------
//   s_        | in        | tdata: rx_byte                          | tvalid/tready
//   m_        | out       | tdata: data_byte, tuser: kind/first/err | tvalid/tready
//   apb       | in        | max_payload_len at byte address 0       | psel/penable
//
// one input beat per cycle while s_tready is high; each beat needs one state update, and its result
// (if any) lands in the output register on the same edge and is seen on m_ after that edge
// type bytes and unknown type bytes give no output beat
// s_tready follows the output register: high when it is empty or being taken
// reset (aresetn low, synchronous) returns to waiting for a type byte and
// sets the length limit to 1024
// ----------------------------------------------------------------------------
module h4_hci_packet_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] data_byte
    output logic [2:0]                    m_tuser,   // [0] packet_kind [1] first_byte [2] status
    output logic                          m_tlast,   // last_byte
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [h4hci_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic             in_ready;
    logic             accept;
    logic [15:0]      max_len;
    h4hci_pkg::beat_t beat;

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    // length limit register
    h4hci_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    // phase tracking and byte tagging
    h4hci_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .max_len (max_len),
        .beat    (beat)
    );

    // result register
    h4hci_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat     (beat),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/h4hci_checker.sv @@
// ----------------------------------------------------------------------------
// h4hci_checker
// port-level checks on the deframer result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h4hci_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // stalled beat holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // no beat straight after reset
    `ASSERT_NEXT_RAW(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // an aborted packet ends on the error beat
    `ASSERT_IMPL(a_err_last, aclk, aresetn, m_tvalid && m_tuser[2], m_tlast)

    // the first header byte never closes a packet
    `ASSERT_IMPL(a_first_not_last, aclk, aresetn, m_tvalid && m_tuser[1], !m_tlast && !m_tuser[2])

endmodule

bind h4_hci_packet_deframer h4hci_checker u_h4hci_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the h4 hci packet deframer: queued uart bytes are
// streamed in, every output beat is checked against a cycle-free deframer
// model, and the length limit is reprogrammed over apb between phases
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_BYTES    = 105;
    localparam int ADDR_W         = h4hci_pkg::PADDR_W;
    localparam logic [ADDR_W-1:0] MAX_LEN_ADDR = ADDR_W'(4 * h4hci_pkg::REG_IDX_MAX_LEN);

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [31:0]          pwdata   = 32'h0;
    logic [31:0]          prdata;
    logic                 pready;

    h4_hci_packet_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // uart bytes waiting to be driven, and beats the deframer model has produced
    logic [7:0]          rx_pending[$];
    h4hci_pkg::beat_t    expected_beats[$];

    // stall percentages, changed by the sequencer between phases
    int send_idle_pct = 13;
    int recv_idle_pct = 86;

    int error_count   = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int aborts_seen   = 0;
    int zero_len_seen = 0;
    int idle_cycles   = 0;

    // deframer model state
    h4hci_pkg::phase_t df_phase     = h4hci_pkg::PH_TYPE;
    logic              df_kind      = h4hci_pkg::KIND_EVT;
    logic [1:0]        df_hdr_count = 2'd0;
    logic [7:0]        df_len_low   = 8'h00;
    logic [15:0]       df_remaining = 16'd0;
    logic [15:0]       df_max_len   = h4hci_pkg::MAX_LEN_RESET;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h (out beat %0d)", what, got, want,
                 beats_out);
        error_count++;
    endtask

    // advance the deframer model by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        h4hci_pkg::beat_t e;
        logic [15:0]      len;
        logic             hdr_done;
        logic             emits;
        e           = '0;
        e.valid     = 1'b1;
        e.data_byte = b;
        e.status    = h4hci_pkg::STATUS_OK;
        hdr_done    = 1'b0;
        emits       = 1'b0;
        len         = 16'd0;
        case (df_phase)
            h4hci_pkg::PH_EVT_HDR: begin
                if (df_hdr_count == 2'd0) begin
                    df_hdr_count = 2'd1;
                    e.first_byte = 1'b1;
                    emits        = 1'b1;
                end else begin
                    len      = {8'h00, b};
                    hdr_done = 1'b1;
                end
            end
            h4hci_pkg::PH_ACL_HDR: begin
                if (df_hdr_count < 2'd3) begin
                    e.first_byte = (df_hdr_count == 2'd0);
                    if (df_hdr_count == 2'd2)
                        df_len_low = b;
                    df_hdr_count = df_hdr_count + 2'd1;
                    emits        = 1'b1;
                end else begin
                    len      = {b, df_len_low};
                    hdr_done = 1'b1;
                end
            end
            h4hci_pkg::PH_PAYLOAD: begin
                if (df_remaining <= 16'd1) begin
                    df_remaining = 16'd0;
                    df_phase     = h4hci_pkg::PH_TYPE;
                    e.last_byte  = 1'b1;
                end else begin
                    df_remaining = df_remaining - 16'd1;
                end
                emits = 1'b1;
            end
            default: begin
                // type byte: never passed on, unknown values dropped
                df_phase     = h4hci_pkg::PH_TYPE;
                df_hdr_count = 2'd0;
                if (b == h4hci_pkg::TYPE_EVT) begin
                    df_kind  = h4hci_pkg::KIND_EVT;
                    df_phase = h4hci_pkg::PH_EVT_HDR;
                end else if (b == h4hci_pkg::TYPE_ACL) begin
                    df_kind  = h4hci_pkg::KIND_ACL;
                    df_phase = h4hci_pkg::PH_ACL_HDR;
                end
            end
        endcase
        if (hdr_done) begin
            e.first_byte = (df_hdr_count == 2'd0);
            df_hdr_count = 2'd0;
            emits        = 1'b1;
            if (len > df_max_len) begin
                e.last_byte = 1'b1;
                e.status    = h4hci_pkg::STATUS_TOO_LONG;
                df_phase    = h4hci_pkg::PH_TYPE;
                aborts_seen++;
            end else if (len == 16'd0) begin
                e.last_byte = 1'b1;
                df_phase    = h4hci_pkg::PH_TYPE;
                zero_len_seen++;
            end else begin
                df_remaining = len;
                df_phase     = h4hci_pkg::PH_PAYLOAD;
            end
        end
        e.packet_kind = df_kind;
        if (emits)
            expected_beats.push_back(e);
    endtask

    // driver: predicts the beat taken at this edge, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                beats_in++;
            end
            // hold the current beat until it is taken
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and field-by-field check of each beat
    h4hci_pkg::beat_t want;
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat, data", m_tdata, 0);
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata != want.data_byte)
                    report_mismatch("data_byte", m_tdata, want.data_byte);
                if (m_tuser[0] != want.packet_kind)
                    report_mismatch("packet_kind", m_tuser[0], want.packet_kind);
                if (m_tuser[1] != want.first_byte)
                    report_mismatch("first_byte", m_tuser[1], want.first_byte);
                if (m_tlast != want.last_byte)
                    report_mismatch("last_byte", m_tlast, want.last_byte);
                if (m_tuser[2] != want.status)
                    report_mismatch("status", m_tuser[2], want.status);
            end
        end
    end

    // watchdog: no beat moving on either side for too long ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // apb write of the length limit; upper data bits carry junk on purpose
    task automatic write_max_len(input logic [15:0] limit);
        logic [31:0] v;
        v = {16'($urandom()), limit};
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        df_max_len  = limit;
    endtask

    // apb read back, compared at the edge that completes the access
    task automatic check_max_len();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MAX_LEN_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[15:0] != df_max_len)
            report_mismatch("max_payload_len readback", prdata[15:0], df_max_len);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one well-formed packet, length picked around the current limit
    task automatic queue_packet(inout int n);
        int   r;
        int   len;
        logic is_acl;
        r      = $urandom_range(0, 99);
        is_acl = 1'($urandom_range(0, 1));
        if (r < 10)
            len = 0;
        else if (r < 68)
            len = $urandom_range(1, 12);
        else if (r < 80)
            len = (df_max_len <= 300) ? int'(df_max_len) : $urandom_range(13, 40);
        else if (r < 94)
            len = (df_max_len < 16'hFFFF) ? int'(df_max_len) + 1 + $urandom_range(0, 2)
                                          : $urandom_range(1, 12);
        else
            len = (df_max_len < 16'hFFFF) ? 65535 : $urandom_range(0, 3);
        if (len > 65535)
            len = 65535;
        if (len > 255)
            is_acl = 1'b1;
        if (is_acl) begin
            rx_pending.push_back(h4hci_pkg::TYPE_ACL);
            rx_pending.push_back(8'($urandom()));
            rx_pending.push_back(8'($urandom()));
            rx_pending.push_back(len[7:0]);
            rx_pending.push_back(len[15:8]);
            n += 5;
        end else begin
            rx_pending.push_back(h4hci_pkg::TYPE_EVT);
            rx_pending.push_back(8'($urandom()));
            rx_pending.push_back(len[7:0]);
            n += 3;
        end
        // aborted packets send no payload here; the next type byte follows
        if (len <= int'(df_max_len)) begin
            for (int i = 0; i < len; i++)
                rx_pending.push_back(8'($urandom()));
            n += len;
        end
    endtask

    // wait until the deframer has nothing left in flight
    task automatic drain();
        while (rx_pending.size() != 0 || s_tvalid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    logic [15:0] phase_limit[6] = '{16'd0, 16'd255, 16'hFFFF, 16'd4, 16'd256, 16'd1024};
    int          phase_mode[6]  = '{0, 0, 1, 1, 2, 2};

    initial begin
        int         n;
        logic [7:0] open_len;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_max_len();

        // directed: unknown types, zero-length event, short event, zero-length acl,
        // acl one above the reset limit (abort), acl with one payload byte
        rx_pending = {8'hFF, 8'h00,
                      h4hci_pkg::TYPE_EVT, 8'h0E, 8'h00,
                      h4hci_pkg::TYPE_EVT, 8'h0F, 8'h02, 8'hAA, 8'h55,
                      h4hci_pkg::TYPE_ACL, 8'h34, 8'h12, 8'h00, 8'h00,
                      h4hci_pkg::TYPE_ACL, 8'hFF, 8'hFF, 8'h01, 8'h04,
                      h4hci_pkg::TYPE_ACL, 8'h80, 8'h7F, 8'h01, 8'h00, 8'hC3};
        drain();

        for (int p = 0; p < 6; p++) begin
            case (phase_mode[p])
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_max_len(phase_limit[p]);
            check_max_len();
            n = 0;
            // finish the acl header left open by the previous phase with a short length
            if (p > 0 && p % 2 == 0) begin
                open_len = 8'($urandom_range(0, 8));
                rx_pending.push_back(open_len);
                rx_pending.push_back(8'h00);
                if (int'(open_len) <= int'(phase_limit[p])) begin
                    for (int i = 0; i < int'(open_len); i++)
                        rx_pending.push_back(8'($urandom()));
                end
            end
            while (n < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 12) begin
                    // noise byte, may well be a type byte
                    rx_pending.push_back(8'($urandom()));
                    n++;
                end else begin
                    queue_packet(n);
                end
            end
            // leave an acl header open so the next limit lands mid-packet
            if (p % 2 == 1)
                rx_pending = {rx_pending, h4hci_pkg::TYPE_ACL, 8'($urandom()), 8'($urandom())};
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (expected_beats.size() != 0) begin
            want = expected_beats.pop_front();
            report_mismatch("missing beat, data", 0, want.data_byte);
        end

        $display("run: %0d bytes in, %0d beats out, %0d length aborts, %0d zero-length packets",
                 beats_in, beats_out, aborts_seen, zero_len_seen);
        $display("limits 1024, 0, 255, 65535, 4, 256, 1024 under three stall patterns");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
